// ----- hdl/mps_pkg.sv -----
// Shared types and constants for the masked point suppression block.
`default_nettype none
package mps_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 10;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int PIX_W       = 8;
    localparam int SEP_W       = 10;
    localparam int DIM_W       = 11;
    localparam int XY_OUT_W    = 10;
    localparam int IDX_OUT_W   = 6;
    localparam int CMP_W       = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (MAX_POINTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_PAD   = NUM_GROUPS * GROUP_SIZE;
    localparam int CFG_IDX_W   = 2;

    localparam logic [PIX_W-1:0] PIXEL_THRESHOLD = PIX_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

    localparam logic [SEP_W-1:0] MIN_SEP_RESET = SEP_W'(5);
    localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(480);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic             shift_en;
        coord_t           probe_x;
        coord_t           probe_y;
        logic [SEP_W-1:0] sep;
        logic [CNT_W-1:0] count;
    } chain_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/mps_cell.sv -----
// One store cell: holds a point, compares it with the probe, passes it on when shifting.
`default_nettype none
module mps_cell import mps_pkg::*; (
    input  wire logic             clk,
    input  wire logic             shift_en,
    input  wire coord_t           load_x,
    input  wire coord_t           load_y,
    input  wire coord_t           probe_x,
    input  wire coord_t           probe_y,
    input  wire logic [SEP_W-1:0] sep,
    input  wire logic             active,
    output coord_t                x,
    output coord_t                y,
    output logic                  hit
);

    coord_t x_reg;
    coord_t y_reg;
    coord_t dx;
    coord_t dy;
    logic   hit_reg;
    logic   hit_next;

    always_comb
    begin
        dx = (probe_x > x_reg) ? probe_x - x_reg : x_reg - probe_x;
        dy = (probe_y > y_reg) ? probe_y - y_reg : y_reg - probe_y;
        hit_next = active
                   && (CMP_W'(dx) < CMP_W'(sep))
                   && (CMP_W'(dy) < CMP_W'(sep));
    end

    // take the neighbor's point (the probe, at the head cell) on a shift; register the hit
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            x_reg <= load_x;
            y_reg <= load_y;
        end
        hit_reg <= hit_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign hit = hit_reg;

endmodule
`default_nettype wire

// ----- hdl/mps_chain.sv -----
// Row of store cells with a registered OR stage over groups of cell hits.
`default_nettype none
module mps_chain import mps_pkg::*; (
    input  wire logic            clk,
    input  wire chain_ctl_t      ctl,
    output logic [NUM_GROUPS-1:0] group_hit
);

    coord_t                  cell_x [MAX_POINTS];
    coord_t                  cell_y [MAX_POINTS];
    logic [GROUP_PAD-1:0]    hit_pad;
    logic [NUM_GROUPS-1:0]   group_reg;
    logic [NUM_GROUPS-1:0]   group_next;

    for (genvar i = 0; i < GROUP_PAD; i++)
    begin : g_cell
        if (i < MAX_POINTS)
        begin : g_real
            coord_t load_x;
            coord_t load_y;
            if (i == 0)
            begin : g_head
                assign load_x = ctl.probe_x;
                assign load_y = ctl.probe_y;
            end
            else
            begin : g_body
                assign load_x = cell_x[i-1];
                assign load_y = cell_y[i-1];
            end

            mps_cell u_cell (
                .clk      (clk),
                .shift_en (ctl.shift_en),
                .load_x   (load_x),
                .load_y   (load_y),
                .probe_x  (ctl.probe_x),
                .probe_y  (ctl.probe_y),
                .sep      (ctl.sep),
                .active   (CNT_W'(i) < ctl.count),
                .x        (cell_x[i]),
                .y        (cell_y[i]),
                .hit      (hit_pad[i])
            );
        end
        else
        begin : g_pad
            assign hit_pad[i] = 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        assign group_next[g] = |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    assign group_hit = group_reg;

endmodule
`default_nettype wire

// ----- hdl/masked_point_suppression_core.sv -----
// Top level: raster position, sequencing, configuration and result register.
// An accepted pixel passes the cell compare, the OR stage and the decide/update
// step, and its result beat is registered; no new pixel is taken until the decide
// step is done, and a stalled result holds the decide step.
// Reset: clears counters, point count, sequencer and result valid; restores
// min_separation 5, image_width 640, image_height 480. Stored points are not cleared.
`default_nettype none
module masked_point_suppression_core import mps_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // pixel channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PIX_W-1:0]     mask_pixel,
    input  wire logic [PIX_W-1:0]     image_pixel,
    input  wire logic                 frame_end,
    // point channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [XY_OUT_W-1:0]       point_x,
    output logic [XY_OUT_W-1:0]       point_y,
    output logic [IDX_OUT_W-1:0]      point_index,
    output logic                      store_overflow,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;   // wait for a pixel beat
    localparam logic [1:0] ST_CMP  = 2'd1;   // cells compare against the probe
    localparam logic [1:0] ST_RED  = 2'd2;   // group ORs settle into registers
    localparam logic [1:0] ST_DEC  = 2'd3;   // decide, update store, emit

    logic [1:0]            state_reg;
    logic [1:0]            state_next;

    // configuration registers
    logic [SEP_W-1:0]      sep_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;

    // raster position and point count
    coord_t                col_reg;
    coord_t                row_reg;
    logic [CNT_W-1:0]      count_reg;

    // the pixel under work
    coord_t                px_reg;
    coord_t                py_reg;
    logic                  cand_reg;
    logic                  last_reg;

    // result register
    logic                  out_valid_reg;
    logic [XY_OUT_W-1:0]   out_x_reg;
    logic [XY_OUT_W-1:0]   out_y_reg;
    logic [IDX_OUT_W-1:0]  out_idx_reg;
    logic                  out_ovf_reg;

    logic                  in_take;
    logic                  out_take;
    logic                  dec_go;
    logic                  hit_any;
    logic                  emit;
    logic                  store_full;
    logic [COORD_BITS:0]   next_col;
    logic [COORD_BITS:0]   next_row;
    logic                  col_wrap;
    logic                  row_wrap;
    chain_ctl_t            chain_ctl;
    logic [NUM_GROUPS-1:0] group_hit;

    // Handshakes. Only one pixel is in flight; the result register parts the
    // decide step from the point channel, so a waiting result that is stalled
    // holds only the decide step.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign dec_go    = (state_reg == ST_DEC) && !(out_valid_reg && out_stall);
    assign cfg_ready = 1'b1;

    assign hit_any    = |group_hit;
    assign store_full = (count_reg == CNT_W'(MAX_POINTS));
    assign emit       = cand_reg && !hit_any;

    // Raster advance: wrap the column at the row width or the top of the
    // coordinate range, and the row likewise against the frame height.
    always_comb
    begin
        next_col = {1'b0, col_reg} + (COORD_BITS+1)'(1);
        next_row = {1'b0, row_reg} + (COORD_BITS+1)'(1);
        col_wrap = (CMP_W'(next_col) >= CMP_W'(width_reg)) || next_col[COORD_BITS];
        row_wrap = (CMP_W'(next_row) >= CMP_W'(height_reg)) || next_row[COORD_BITS];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_CMP;
            ST_CMP:  state_next = ST_RED;
            ST_RED:  state_next = ST_DEC;
            ST_DEC:  if (dec_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg    <= MIN_SEP_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_SEP: sep_reg    <= cfg_data[SEP_W-1:0];
                REG_WIDTH:   width_reg  <= cfg_data;
                REG_HEIGHT:  height_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Position advances at the pixel beat; frame_end returns it to the origin.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_take)
        begin
            if (frame_end)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + COORD_BITS'(1);
            end
            else
            begin
                col_reg <= next_col[COORD_BITS-1:0];
            end
        end
    end

    // Capture the pixel under work; hold it until the decide step is done.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            px_reg   <= col_reg;
            py_reg   <= row_reg;
            cand_reg <= (mask_pixel > PIXEL_THRESHOLD) && (image_pixel > PIXEL_THRESHOLD);
            last_reg <= frame_end;
        end
    end

    // Point count: bump on a store, drop to zero after the last pixel of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dec_go)
        begin
            if (last_reg)
            begin
                count_reg <= '0;
            end
            else if (emit && !store_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // The new point enters at the head of the cell row and every stored
    // point moves one cell down; order inside the row does not matter.
    always_comb
    begin
        chain_ctl.shift_en = dec_go && emit && !store_full;
        chain_ctl.probe_x  = px_reg;
        chain_ctl.probe_y  = py_reg;
        chain_ctl.sep      = sep_reg;
        chain_ctl.count    = count_reg;
    end

    mps_chain u_chain (
        .clk       (clk),
        .ctl       (chain_ctl),
        .group_hit (group_hit)
    );

    // Result register: load on an emitted point, clear when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dec_go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_go && emit)
        begin
            out_x_reg   <= XY_OUT_W'(px_reg);
            out_y_reg   <= XY_OUT_W'(py_reg);
            out_idx_reg <= store_full ? '0 : IDX_OUT_W'(count_reg);
            out_ovf_reg <= store_full;
        end
    end

    assign out_valid      = out_valid_reg;
    assign point_x        = out_x_reg;
    assign point_y        = out_y_reg;
    assign point_index    = out_idx_reg;
    assign store_overflow = out_ovf_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_CMP))
        else $error("accepted pixel did not enter compare step");

    a_out_from_dec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DEC))
        else $error("result raised outside decide step");

    a_full_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        store_full |-> !chain_ctl.shift_en)
        else $error("shift into a full store");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_masked_point_suppression_core.sv -----
// Self-checking testbench for masked_point_suppression_core with its own point-store predictor.
module tb_masked_point_suppression_core;
    import mps_pkg::*;

    // Largest coordinate a counter can hold.
    localparam int COORD_TOP = (1 << COORD_BITS) - 1;
    // Index that selects no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Cycles without any beat before the run is declared hung.
    localparam int HANG_LIMIT = 300;
    // Cycles to let an in-flight pixel finish after the last result arrived.
    localparam int SETTLE_CYCLES = 8;

    // One result beat as it appears on the point channel.
    typedef struct packed {
        logic [XY_OUT_W-1:0]  x;
        logic [XY_OUT_W-1:0]  y;
        logic [IDX_OUT_W-1:0] index;
        logic                 overflow;
    } point_beat_t;

    // Mirror of the block: raster position, stored points and registers.
    // Accepted pixels advance it; the points it would emit wait in a FIFO.
    class point_store_mirror;
        logic [SEP_W-1:0] min_sep = MIN_SEP_RESET;
        logic [DIM_W-1:0] frame_w = WIDTH_RESET;
        logic [DIM_W-1:0] frame_h = HEIGHT_RESET;
        int               col = 0;
        int               row = 0;
        int               fill = 0;
        int               stored_col [MAX_POINTS];
        int               stored_row [MAX_POINTS];
        point_beat_t      pending_points [$];
        int               bad_points = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                REG_MIN_SEP: min_sep = data[SEP_W-1:0];
                REG_WIDTH:   frame_w = data;
                REG_HEIGHT:  frame_h = data;
                default:     ;
            endcase
        endfunction

        function int gap_between(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Strict test on both axes; a separation of zero suppresses nothing.
        function bit near_stored(int x, int y);
            for (int k = 0; k < fill; k++)
                if (gap_between(x, stored_col[k]) < int'(min_sep) &&
                    gap_between(y, stored_row[k]) < int'(min_sep))
                    return 1'b1;
            return 1'b0;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] m, logic [PIX_W-1:0] img, logic last);
            point_beat_t b;
            int          next_col;
            int          next_row;
            if (m > PIXEL_THRESHOLD && img > PIXEL_THRESHOLD && !near_stored(col, row))
            begin
                b.x = XY_OUT_W'(col);
                b.y = XY_OUT_W'(row);
                if (fill < MAX_POINTS)
                begin
                    stored_col[fill] = col;
                    stored_row[fill] = row;
                    b.index    = IDX_OUT_W'(fill);
                    b.overflow = 1'b0;
                    fill++;
                end
                else
                begin
                    // Store full: drop the point, flag it, report slot zero.
                    b.index    = '0;
                    b.overflow = 1'b1;
                end
                pending_points = {pending_points, b};
            end
            if (last)
            begin
                col  = 0;
                row  = 0;
                fill = 0;
            end
            else
            begin
                // Wrap the column at the row end, the row at the frame end; keep the store.
                next_col = col + 1;
                if (next_col >= int'(frame_w) || next_col > COORD_TOP)
                begin
                    col      = 0;
                    next_row = row + 1;
                    row = (next_row >= int'(frame_h) || next_row > COORD_TOP) ? 0 : next_row;
                end
                else
                    col = next_col;
            end
        endfunction

        function void match_point(point_beat_t got);
            point_beat_t want;
            if (pending_points.size() == 0)
            begin
                bad_points++;
                if (bad_points <= 10)
                    $display("point beat with none pending: x=%0d y=%0d index=%0d overflow=%0b",
                             got.x, got.y, got.index, got.overflow);
                return;
            end
            want = pending_points.pop_front();
            if (got !== want)
            begin
                bad_points++;
                if (bad_points <= 10)
                    $display("point mismatch: want x=%0d y=%0d index=%0d overflow=%0b,",
                             want.x, want.y, want.index, want.overflow,
                             " got x=%0d y=%0d index=%0d overflow=%0b",
                             got.x, got.y, got.index, got.overflow);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     mask_pixel = '0;
    logic [PIX_W-1:0]     image_pixel = '0;
    logic                 frame_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [XY_OUT_W-1:0]  point_x;
    logic [XY_OUT_W-1:0]  point_y;
    logic [IDX_OUT_W-1:0] point_index;
    logic                 store_overflow;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    point_store_mirror mirror = new;
    bit                steady = 1'b0;   // when set, neither side idles or stalls
    int                out_hold = 0;
    int                idle_cycles = 0;

    masked_point_suppression_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mask_pixel     (mask_pixel),
        .image_pixel    (image_pixel),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_index    (point_index),
        .store_overflow (store_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // Sample every channel at the edge. Check the result beat before noting
    // a new pixel so a stray beat can never pair with a fresh expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            mirror.match_point({point_x, point_y, point_index, store_overflow});
            // Draw how long to stall the next result beat.
            out_hold = steady ? 0 : $urandom_range(0, 3);
        end
        else if (rst_n && out_valid && out_hold != 0)
            out_hold--;
        out_stall <= (out_hold != 0);

        if (rst_n && cfg_valid && cfg_ready)
            mirror.write_reg(cfg_index, cfg_data);
        if (rst_n && in_valid && !in_stall)
            mirror.take_pixel(mask_pixel, image_pixel, frame_end);

        if ((out_valid && !out_stall) || (cfg_valid && cfg_ready) || (in_valid && !in_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // Present one pixel beat after a random gap and hold it until accepted.
    // Valid stays high across back-to-back beats; drop it only for a gap.
    task automatic send_pixel(input logic [PIX_W-1:0] m, input logic [PIX_W-1:0] img,
                              input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mask_pixel  <= m;
        image_pixel <= img;
        frame_end   <= last;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait for every expected point, then let any pixel still in flight drain.
    task automatic settle();
        while (mirror.pending_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back, optionally after a write to the
    // unused index.
    task automatic program_regs(input logic [DIM_W-1:0] sep, input logic [DIM_W-1:0] w,
                                input logic [DIM_W-1:0] h, input bit spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [DIM_W-1:0]     val [4];
        int                   first;
        idx[0] = REG_SPARE;   val[0] = DIM_W'($urandom);
        idx[1] = REG_MIN_SEP; val[1] = sep;
        idx[2] = REG_WIDTH;   val[2] = w;
        idx[3] = REG_HEIGHT;  val[3] = h;
        first = spare ? 0 : 1;
        for (int i = first; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stream a run of pixels: mostly candidates with random bytes, the rest
    // noise; end frames at random and optionally close the frame on the last beat.
    task automatic stream_pixels(input int count, input int cand_pct, input int end_pct,
                                 input bit close_frame);
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] img;
        logic             last;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < cand_pct)
            begin
                m   = PIX_W'($urandom_range(101, 255));
                img = PIX_W'($urandom_range(101, 255));
            end
            else
            begin
                m   = PIX_W'($urandom);
                img = PIX_W'($urandom);
            end
            last = ($urandom_range(0, 99) < end_pct) || (close_frame && i == count - 1);
            send_pixel(m, img, last);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [DIM_W-1:0] sep_v;
        logic [DIM_W-1:0] w_v;
        logic [DIM_W-1:0] h_v;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under reset settings (separation 5, one long row).
        send_pixel(8'd255, 8'd255, 1'b0);  // (0,0) accepted, slot 0
        send_pixel(8'd0,   8'd0,   1'b0);  // not a candidate
        send_pixel(8'd101, 8'd101, 1'b0);  // just above threshold, too close
        send_pixel(8'd100, 8'd255, 1'b0);  // mask at threshold: ignored
        send_pixel(8'd255, 8'd100, 1'b0);  // image at threshold: ignored
        send_pixel(8'd101, 8'd255, 1'b0);  // dx equals separation: accepted
        send_pixel(8'd128, 8'd128, 1'b0);  // suppressed
        send_pixel(8'd127, 8'd200, 1'b0);  // suppressed
        send_pixel(8'h55,  8'hAA,  1'b0);  // alternating bits, no candidate
        send_pixel(8'hAA,  8'h55,  1'b0);
        send_pixel(8'd200, 8'd200, 1'b0);  // (10,0) accepted, slot 2
        send_pixel(8'd255, 8'd255, 1'b1);  // suppressed candidate ends the frame
        send_pixel(8'd255, 8'd255, 1'b0);  // store empty again: slot 0
        send_pixel(8'd101, 8'd101, 1'b0);
        send_pixel(8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 1'b1);  // accepted on the frame-end beat
        send_pixel(8'd255, 8'd255, 1'b0);
        in_valid <= 1'b0;

        // Zero separation on a tiny frame: fill the store and run into overflow.
        settle();
        program_regs(11'd0, 11'd4, 11'd3, 1'b0);
        stream_pixels(80, 100, 0, 1'b0);

        // Widest separation and largest frame: nearly everything suppressed.
        settle();
        steady = 1'b1;
        program_regs(11'd1023, 11'd1024, 11'd1024, 1'b1);
        stream_pixels(40, 80, 2, 1'b1);

        // One-pixel frame: every beat lands on (0,0).
        settle();
        steady = 1'b0;
        program_regs(11'd1, 11'd1, 11'd1, 1'b0);
        stream_pixels(30, 70, 5, 1'b0);

        // Random frames, mostly small, and small separations; bit 10 of the separation write
        // must be ignored.
        for (int p = 0; p < 6; p++)
        begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            sep_v  = DIM_W'($urandom_range(0, 6)) | (DIM_W'($urandom_range(0, 1)) << 10);
            w_v    = (p == 2) ? 11'd1024 : DIM_W'($urandom_range(1, 12));
            h_v    = (p == 4) ? 11'd1024 : DIM_W'($urandom_range(1, 6));
            program_regs(sep_v, w_v, h_v, p[0]);
            stream_pixels(45, 60, 3, p[0]);
        end

        settle();
        if (mirror.bad_points == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // End a hung run: too long with no beat on any channel.
    initial
    begin
        while (idle_cycles < HANG_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

endmodule
